// ===== rtl/core/ncf_pkg.sv =====
// ----------------------------------------------------------------------------
// ncf_pkg
// Shared widths, register indexes, reset values and types of the
// neighbour count cell filter.
// ----------------------------------------------------------------------------
package ncf_pkg;

  localparam int unsigned MAX_COLUMNS_DEF = 256;
  localparam int unsigned MAX_ROWS_DEF    = 256;

  localparam int unsigned COLS_W     = 9;
  localparam int unsigned ROWS_W     = 9;
  localparam int unsigned MINW_W     = 4;
  localparam int unsigned ORMAX_W    = 5;
  localparam int unsigned CHANCE_W   = 17;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned RND_W      = 16;
  localparam int unsigned WIN_W      = 9;

  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned M_TDATA_W = 8;

  localparam logic [CFG_IDX_W-1:0] CFG_COLUMNS      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_WALLS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_OR_MAX_WALLS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CHANCE       = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ONLY_TO_WALL = 3'd5;

  localparam logic [COLS_W-1:0]   COLUMNS_RST      = 9'd64;
  localparam logic [ROWS_W-1:0]   ROWS_RST         = 9'd64;
  localparam logic [MINW_W-1:0]   MIN_WALLS_RST    = 4'd5;
  localparam logic [ORMAX_W-1:0]  OR_MAX_WALLS_RST = 5'd1;
  localparam logic [CHANCE_W-1:0] CHANCE_RST       = 17'd43909;

  localparam int unsigned OUT_FIFO_DEPTH = 3;
  localparam int unsigned OUT_CNT_W      = 2;

  typedef struct packed {
    logic [MINW_W-1:0]   min_walls;
    logic [ORMAX_W-1:0]  or_max_walls;
    logic [CHANCE_W-1:0] chance;
    logic                only_to_wall;
  } ncf_rule_t;

  typedef struct packed {
    logic last;
    logic new_wall;
  } ncf_res_t;

endpackage

// ===== rtl/core/ncf_decide.sv =====
// ----------------------------------------------------------------------------
// ncf_decide
// Counts the walls of a 3x3 window and applies the smoothing rule.
// ----------------------------------------------------------------------------
module ncf_decide import ncf_pkg::*; (
  input  logic [WIN_W-1:0] win_i,
  input  logic [RND_W-1:0] rnd_i,
  input  ncf_rule_t        rule_i,
  output logic             wall_o
);

  logic [3:0]        cnt;
  logic signed [5:0] cnt_s;
  logic signed [5:0] lo_s;
  logic signed [5:0] hi_s;
  logic              lucky;

  always_comb begin
    cnt = '0;
    for (int k = 0; k < WIN_W; k++) begin
      cnt = cnt + 4'(win_i[k]);
    end
  end

  assign cnt_s = $signed({2'b00, cnt});
  assign hi_s  = $signed({2'b00, rule_i.min_walls});
  assign lo_s  = $signed({rule_i.or_max_walls[ORMAX_W-1], rule_i.or_max_walls});
  assign lucky = ({1'b0, rnd_i} < rule_i.chance);

  assign wall_o = (rule_i.only_to_wall && win_i[4]) || (cnt_s > hi_s) || (cnt_s < lo_s)
                  || (((cnt_s == hi_s) || (cnt_s == lo_s)) && lucky);

endmodule

// ===== rtl/core/ncf_line_mem.sv =====
// ----------------------------------------------------------------------------
// ncf_line_mem
// Line buffer memory, one word per column holding the cells of the two
// previous rows, with a registered read and write-to-read forwarding.
// ----------------------------------------------------------------------------
module ncf_line_mem #(
  parameter int unsigned DEPTH = 256,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  input  logic          wr_en_i,
  input  logic [AW-1:0] wr_addr_i,
  input  logic [1:0]    wr_data_i,
  output logic [1:0]    rd_data_o
);

  logic [1:0] mem_q [DEPTH];
  logic [1:0] rd_q;
  logic [1:0] fwd_data_q;
  logic       fwd_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_q <= mem_q[rd_addr_i];
    end
    fwd_data_q <= wr_data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q <= 1'b0;
    end else if (rd_en_i) begin
      fwd_q <= wr_en_i && (wr_addr_i == rd_addr_i);
    end
  end

  assign rd_data_o = fwd_q ? fwd_data_q : rd_q;

endmodule

// ===== rtl/core/ncf_out_fifo.sv =====
// ----------------------------------------------------------------------------
// ncf_out_fifo
// Small result queue that decouples the output handshake from the filter
// pipeline.
// ----------------------------------------------------------------------------
module ncf_out_fifo import ncf_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  ncf_res_t             push_data_i,
  input  logic                 pop_i,
  output logic                 valid_o,
  output ncf_res_t             data_o,
  output logic [OUT_CNT_W-1:0] count_o
);

  localparam int unsigned PTR_W = $clog2(OUT_FIFO_DEPTH);

  ncf_res_t             entry_q [OUT_FIFO_DEPTH];
  logic [PTR_W-1:0]     head_q;
  logic [PTR_W-1:0]     head_d;
  logic [PTR_W-1:0]     tail_q;
  logic [PTR_W-1:0]     tail_d;
  logic [OUT_CNT_W-1:0] cnt_q;
  logic [OUT_CNT_W-1:0] cnt_d;
  logic                 do_pop;

  assign valid_o = (cnt_q != '0);
  assign data_o  = entry_q[head_q];
  assign count_o = cnt_q;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    cnt_d  = cnt_q;
    if (do_pop) begin
      head_d = (head_q == PTR_W'(OUT_FIFO_DEPTH - 1)) ? '0 : head_q + PTR_W'(1);
    end
    if (push_i) begin
      tail_d = (tail_q == PTR_W'(OUT_FIFO_DEPTH - 1)) ? '0 : tail_q + PTR_W'(1);
    end
    if (push_i && !do_pop) begin
      cnt_d = cnt_q + OUT_CNT_W'(1);
    end else if (do_pop && !push_i) begin
      cnt_d = cnt_q - OUT_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[tail_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      cnt_q  <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
      cnt_q  <= cnt_d;
    end
  end

endmodule

// ===== rtl/core/neighbour_count_cell_filter.sv =====
// ----------------------------------------------------------------------------
// neighbour_count_cell_filter
// One generation of a 3x3 cave-smoothing cellular automaton over a raster
// stream of wall and space cells, with line buffers in a memory.
//
//   Channel   Direction  Handshake                    Payload
//   s_axis    in         s_axis_tvalid/s_axis_tready  tdata, tuser
//   m_axis    out        m_axis_tvalid/m_axis_tready  tdata, tlast
//   cfg       in         cfg_we_i                     cfg_index_i, cfg_data_i
//
// One request is taken every cycle while input ready is high. A request
// is registered in the window stage as the line memory reads its column,
// and its result is registered in the result queue. Results lag the
// grid by one row plus one cell. The line memory needs no clearing after
// reset. Input ready drops when the queued results and a request in the
// window stage together reach three, the depth of the result queue.
// ----------------------------------------------------------------------------
module neighbour_count_cell_filter import ncf_pkg::*; #(
  parameter int unsigned MAX_COLUMNS = MAX_COLUMNS_DEF,
  parameter int unsigned MAX_ROWS    = MAX_ROWS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  input  logic [S_TDATA_W-1:0]  s_axis_tdata,  // is_wall, random, zero fill
  input  logic                  s_axis_tuser,  // func
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]  m_axis_tdata,  // new_wall, zero fill
  output logic                  m_axis_tlast,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i
);

  localparam int unsigned CW  = $clog2(MAX_COLUMNS);
  localparam int unsigned WW  = $clog2(MAX_COLUMNS + 1);
  localparam int unsigned RW  = $clog2(MAX_ROWS + 3);
  localparam int unsigned CCW = (WW > COLS_W) ? WW : COLS_W;
  localparam int unsigned RCW = (RW > ROWS_W) ? RW : ROWS_W;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_FINISH,
    OP_CELL
  } op_e;

  typedef struct packed {
    op_e              op;
    logic             eject;
    logic             first_col;
    logic             emit;
    logic             top_ok;
    logic             mid_ok;
    logic             bot_ok;
    logic             wall;
    logic [RND_W-1:0] rnd;
    logic [CW-1:0]    addr;
  } stage_t;

  logic [COLS_W-1:0]   columns_q;
  logic [ROWS_W-1:0]   rows_q;
  logic [MINW_W-1:0]   min_walls_q;
  logic [ORMAX_W-1:0]  or_max_walls_q;
  logic [CHANCE_W-1:0] chance_q;
  logic                only_to_wall_q;
  ncf_rule_t           rule;

  logic [CCW-1:0] cols_ext;
  logic [CCW-1:0] cols_clamp;
  logic [WW-1:0]  w_len;
  logic [RCW-1:0] rows_ext;
  logic [RCW-1:0] rows_clamp;
  logic [RW-1:0]  h_len;
  logic [RW-1:0]  h_p1;
  logic [RW-1:0]  h_p2;

  logic [CW-1:0] col_q;
  logic [CW-1:0] col_d;
  logic [RW-1:0] row_q;
  logic [RW-1:0] row_d;
  logic [WW-1:0] col_inc;

  logic             s_fire;
  logic             in_func;
  logic             in_wall;
  logic [RND_W-1:0] in_rnd;
  logic             is_drop;
  logic             is_ignore;
  logic             is_finish;

  stage_t s1_d;
  stage_t s1_q;
  logic   s1_valid_q;

  logic [1:0]       rd_data;
  logic             top_bit;
  logic             mid_bit;
  logic             bot_bit;
  logic [2:0]       col3;
  logic [WIN_W-1:0] win_q;
  logic [WIN_W-1:0] win_d;
  logic [WIN_W-1:0] win_new;
  logic [WIN_W-1:0] dec_win;
  logic             dec_wall;
  logic             wr_en;

  logic                 out_push;
  ncf_res_t             out_res;
  ncf_res_t             fifo_data;
  logic [OUT_CNT_W-1:0] fifo_cnt;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      columns_q      <= COLUMNS_RST;
      rows_q         <= ROWS_RST;
      min_walls_q    <= MIN_WALLS_RST;
      or_max_walls_q <= OR_MAX_WALLS_RST;
      chance_q       <= CHANCE_RST;
      only_to_wall_q <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        CFG_COLUMNS:      columns_q      <= cfg_data_i[COLS_W-1:0];
        CFG_ROWS:         rows_q         <= cfg_data_i[ROWS_W-1:0];
        CFG_MIN_WALLS:    min_walls_q    <= cfg_data_i[MINW_W-1:0];
        CFG_OR_MAX_WALLS: or_max_walls_q <= cfg_data_i[ORMAX_W-1:0];
        CFG_CHANCE:       chance_q       <= cfg_data_i[CHANCE_W-1:0];
        CFG_ONLY_TO_WALL: only_to_wall_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign rule = '{min_walls: min_walls_q, or_max_walls: or_max_walls_q,
                  chance: chance_q, only_to_wall: only_to_wall_q};

  assign cols_ext   = CCW'(columns_q);
  assign cols_clamp = (cols_ext == '0) ? CCW'(1) :
                      (cols_ext > CCW'(MAX_COLUMNS)) ? CCW'(MAX_COLUMNS) : cols_ext;
  assign w_len      = WW'(cols_clamp);
  assign rows_ext   = RCW'(rows_q);
  assign rows_clamp = (rows_ext == '0) ? RCW'(1) :
                      (rows_ext > RCW'(MAX_ROWS)) ? RCW'(MAX_ROWS) : rows_ext;
  assign h_len      = RW'(rows_clamp);
  assign h_p1       = h_len + RW'(1);
  assign h_p2       = h_len + RW'(2);

  assign s_fire  = s_axis_tvalid && s_axis_tready;
  assign in_func = s_axis_tuser;
  assign in_wall = s_axis_tdata[0];
  assign in_rnd  = s_axis_tdata[RND_W:1];

  assign is_drop   = (row_q > h_p1);
  assign is_ignore = !is_drop && (row_q < h_len) && in_func;
  assign is_finish = !is_drop && (col_q == '0) && (row_q == h_p1);
  assign col_inc   = WW'(col_q) + WW'(1);

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (s_fire) begin
      priority if (is_drop || is_finish) begin
        col_d = '0;
        row_d = '0;
      end else if (is_ignore) begin
        col_d = col_q;
        row_d = row_q;
      end else begin
        if (col_inc >= w_len) begin
          col_d = '0;
          row_d = row_q + RW'(1);
        end else begin
          col_d = CW'(col_inc);
        end
      end
    end
  end

  always_comb begin
    s1_d.op        = is_drop ? OP_CLEAR : (is_finish ? OP_FINISH : OP_CELL);
    s1_d.eject     = (col_q == '0) && (row_q >= RW'(2));
    s1_d.first_col = (col_q == '0);
    s1_d.emit      = (col_q != '0) && (row_q >= RW'(1)) && (row_q <= h_len);
    s1_d.top_ok    = (row_q >= RW'(2)) && (row_q < h_p2);
    s1_d.mid_ok    = (row_q >= RW'(1)) && (row_q < h_p1);
    s1_d.bot_ok    = (row_q < h_len);
    s1_d.wall      = in_wall;
    s1_d.rnd       = in_rnd;
    s1_d.addr      = col_q;
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      s1_q <= s1_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q      <= '0;
      row_q      <= '0;
      s1_valid_q <= 1'b0;
      win_q      <= '0;
    end else begin
      col_q      <= col_d;
      row_q      <= row_d;
      s1_valid_q <= s_fire && !is_ignore;
      win_q      <= win_d;
    end
  end

  ncf_line_mem #(
    .DEPTH (MAX_COLUMNS)
  ) u_line_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (s_fire),
    .rd_addr_i (col_q),
    .wr_en_i   (wr_en),
    .wr_addr_i (s1_q.addr),
    .wr_data_i ({bot_bit, rd_data[1]}),
    .rd_data_o (rd_data)
  );

  assign top_bit = s1_q.top_ok ? rd_data[0] : 1'b1;
  assign mid_bit = s1_q.mid_ok ? rd_data[1] : 1'b1;
  assign bot_bit = s1_q.bot_ok ? s1_q.wall : 1'b1;
  assign col3    = {bot_bit, mid_bit, top_bit};
  assign win_new = s1_q.first_col ? {col3, 6'h3F} : {col3, win_q[WIN_W-1:3]};
  assign wr_en   = s1_valid_q && (s1_q.op == OP_CELL);

  always_comb begin
    win_d = win_q;
    if (s1_valid_q) begin
      unique case (s1_q.op)
        OP_CELL: win_d = win_new;
        default: win_d = '0;
      endcase
    end
  end

  assign dec_win = ((s1_q.op == OP_FINISH) || s1_q.eject) ? {3'b111, win_q[WIN_W-1:3]}
                                                          : win_new;

  ncf_decide u_decide (
    .win_i  (dec_win),
    .rnd_i  (s1_q.rnd),
    .rule_i (rule),
    .wall_o (dec_wall)
  );

  assign out_push = s1_valid_q && ((s1_q.op == OP_FINISH) ||
                    ((s1_q.op == OP_CELL) && (s1_q.eject || s1_q.emit)));
  assign out_res  = '{last: (s1_q.op == OP_FINISH), new_wall: dec_wall};

  ncf_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (out_push),
    .push_data_i (out_res),
    .pop_i       (m_axis_tready),
    .valid_o     (m_axis_tvalid),
    .data_o      (fifo_data),
    .count_o     (fifo_cnt)
  );

  assign s_axis_tready = (({1'b0, fifo_cnt} + 3'(s1_valid_q)) < 3'(OUT_FIFO_DEPTH));
  assign m_axis_tdata  = {{(M_TDATA_W - 1){1'b0}}, fifo_data.new_wall};
  assign m_axis_tlast  = fifo_data.last;

`ifndef SYNTHESIS
  a_fifo_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_push |-> (fifo_cnt != OUT_CNT_W'(OUT_FIFO_DEPTH)))
    else $error("Result pushed into a full queue.");

  a_finish_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_fire && is_finish) |=> ((row_q == '0) && (col_q == '0) && s1_valid_q))
    else $error("Frame end did not rewind the raster position.");

  a_stage_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> $past(s_fire))
    else $error("Window stage active without an accepted request.");

  a_write_only_cells: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && (s1_q.op != OP_CELL)) |-> (!wr_en && (win_d == '0)))
    else $error("Line memory written or window kept on a frame boundary.");
`endif

endmodule
